// ----- rtl/core/htbd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package htbd_pkg;

  // Fixed field widths of the item and result channels.
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned CODE_W     = 16;
  localparam int unsigned CODE_IDX_W = 4;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned STATUS_W   = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DECODE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END    = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADLEN  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADPATH = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/core/huffman_tree_bit_decoder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake             | Payload
// -------- | --------- | --------------------- | ------------------------------------------
// item     | in        | in_valid_i/in_stall_o | command, symbol_in, code_bits, code_length,
//          |           |                       | bit_value
// result   | out       | out_valid_o/out_stall_i | symbol_valid, symbol_out, status
//
// A decode or end item is split into the transfer, which reads the current node, and a
// decode or end step that then acts on the registered entry. A load walks one tree level
// per step, with the next node's read overlapped with the last one's write-back, then writes
// the leaf; a rejected load ends in its error result at once. Reset clears the walk, the
// root's children and the free count; the memory is not cleared since only allocated
// nodes are read. A stalled result holds the block in the step that makes the next one.

module huffman_tree_bit_decoder_unit
  import htbd_pkg::*;
#(
  parameter int unsigned SYMBOL_COUNT = 256,
  parameter int unsigned NODE_COUNT   = 511,
  parameter int unsigned MAX_CODE_LEN = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,

  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire  [CMD_W-1:0]    command_i,
  input  wire  [SYM_W-1:0]    symbol_in_i,
  input  wire  [CODE_W-1:0]   code_bits_i,
  input  wire  [LEN_W-1:0]    code_length_i,
  input  wire                 bit_value_i,

  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic                symbol_valid_o,
  output logic [SYM_W-1:0]    symbol_out_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int unsigned IDX_W = $clog2(NODE_COUNT);
  localparam int unsigned CNT_W = $clog2(NODE_COUNT + 1);

  // One tree node as it sits in the memory. A child index of zero means the
  // child is absent, since the root is never anybody's child.
  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic             leaf;
    logic [SYM_W-1:0] sym;
  } node_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_LEAF,
    S_DEC,
    S_END
  } state_e;

  state_e state_q;

  // Walk and allocation state.
  logic [IDX_W-1:0] cur_q;
  logic [CNT_W-1:0] next_free_q;
  logic [IDX_W-1:0] root_left_q;
  logic [IDX_W-1:0] root_right_q;

  // Load walk.
  logic [IDX_W-1:0]  ld_node_q;
  logic              fresh_q;
  logic              bad_q;
  logic [LEN_W-1:0]  pos_q;
  logic [IDX_W-1:0]  leaf_idx_q;

  // Item payload held for the duration of the item.
  logic [SYM_W-1:0]  sym_q;
  logic [CODE_W-1:0] code_q;
  logic              bit_q;

  // Result register.
  logic                out_valid_q;
  logic                sym_valid_q;
  logic [SYM_W-1:0]    sym_out_q;
  logic [STATUS_W-1:0] status_q;

  // Node memory, one read and one write port, registered read data.
  node_t mem [NODE_COUNT];
  node_t rdata_q;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  node_t            mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;

  logic             in_xfer;
  logic             out_free;
  logic             res_set;
  logic [IDX_W-1:0] node_sel;
  node_t            ent;
  node_t            ent_upd;
  logic             ld_bit;
  logic             ld_last;
  logic [IDX_W-1:0] ld_child;
  logic             ld_alloc;
  logic             store_full;
  logic [IDX_W-1:0] new_idx;
  logic [IDX_W-1:0] dec_child;
  logic [IDX_W-1:0] root_child;
  logic             end_emit;
  logic             load_bad;

  assign in_stall_o     = (state_q != S_IDLE);
  assign in_xfer        = in_valid_i && !in_stall_o;
  assign out_free       = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign symbol_valid_o = sym_valid_q;
  assign symbol_out_o   = sym_out_q;
  assign status_o       = status_q;

  assign load_bad = (code_length_i == '0) || (int'(code_length_i) > MAX_CODE_LEN) ||
                    (int'(symbol_in_i) >= SYMBOL_COUNT);

  always_comb begin
    node_sel = (state_q == S_LOAD) ? ld_node_q : cur_q;
    if (node_sel == '0) begin
      ent       = '0;
      ent.left  = root_left_q;
      ent.right = root_right_q;
    end else if (state_q == S_LOAD && fresh_q) begin
      // A node allocated earlier in this walk is still all zero.
      ent = '0;
    end else begin
      ent = rdata_q;
    end

    // Code bits beyond the input field read as zero.
    ld_bit     = (pos_q >= LEN_W'(CODE_W)) ? 1'b0 : code_q[pos_q[CODE_IDX_W-1:0]];
    ld_last    = (pos_q == '0);
    ld_child   = ld_bit ? ent.right : ent.left;
    ld_alloc   = ld_last || (ld_child == '0);
    store_full = (next_free_q == CNT_W'(NODE_COUNT));
    new_idx    = next_free_q[IDX_W-1:0];

    // Any node on a load path becomes internal; a missing child or the last
    // bit gets the next free node.
    ent_upd      = ent;
    ent_upd.leaf = 1'b0;
    if (ld_alloc && !store_full) begin
      if (ld_bit) begin
        ent_upd.right = new_idx;
      end else begin
        ent_upd.left = new_idx;
      end
    end

    dec_child  = bit_q ? ent.right : ent.left;
    root_child = bit_q ? root_right_q : root_left_q;
    end_emit   = ent.leaf || (cur_q != '0);

    mem_we    = 1'b0;
    mem_waddr = ld_node_q;
    mem_wdata = ent_upd;
    mem_re    = 1'b0;
    mem_raddr = cur_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer && (command_i == CMD_DECODE || command_i == CMD_END) && cur_q != '0) begin
          mem_re = 1'b1;
        end
      end
      S_LOAD: begin
        if (!bad_q) begin
          // The write-back of a node where the store runs full also produces
          // a result, so it waits for the result register.
          if (ld_node_q != '0 && (!(ld_alloc && store_full) || out_free)) begin
            mem_we = 1'b1;
          end
          if (!ld_alloc) begin
            mem_re    = 1'b1;
            mem_raddr = ld_child;
          end
        end
      end
      S_LEAF: begin
        if (out_free) begin
          mem_we         = 1'b1;
          mem_waddr      = leaf_idx_q;
          mem_wdata      = '0;
          mem_wdata.leaf = 1'b1;
          mem_wdata.sym  = sym_q;
        end
      end
      default: begin
      end
    endcase

    // A new result enters the result register in this cycle.
    case (state_q)
      S_LOAD:  res_set = out_free && (bad_q || (ld_alloc && store_full));
      S_LEAF:  res_set = out_free;
      S_DEC:   res_set = out_free && (dec_child == '0);
      S_END:   res_set = out_free && end_emit;
      default: res_set = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_q        <= '0;
      next_free_q  <= CNT_W'(1);
      root_left_q  <= '0;
      root_right_q <= '0;
      ld_node_q    <= '0;
      fresh_q      <= 1'b0;
      bad_q        <= 1'b0;
      pos_q        <= '0;
      leaf_idx_q   <= '0;
      sym_q        <= '0;
      code_q       <= '0;
      bit_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      sym_valid_q  <= 1'b0;
      sym_out_q    <= '0;
      status_q     <= ST_OK;
    end else begin
      if (res_set) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            sym_q     <= symbol_in_i;
            code_q    <= code_bits_i;
            bit_q     <= bit_value_i;
            pos_q     <= code_length_i - LEN_W'(1);
            bad_q     <= load_bad;
            ld_node_q <= '0;
            fresh_q   <= 1'b0;
            case (command_i)
              CMD_LOAD:   state_q <= S_LOAD;
              CMD_DECODE: state_q <= S_DEC;
              CMD_END:    state_q <= S_END;
              default:    state_q <= S_IDLE;
            endcase
          end
        end

        S_LOAD: begin
          if (bad_q) begin
            if (out_free) begin
              sym_valid_q <= 1'b0;
              sym_out_q   <= '0;
              status_q    <= ST_BADLEN;
              state_q     <= S_IDLE;
            end
          end else if (ld_alloc && store_full) begin
            if (out_free) begin
              sym_valid_q <= 1'b0;
              sym_out_q   <= '0;
              status_q    <= ST_FULL;
              state_q     <= S_IDLE;
            end
          end else begin
            if (ld_node_q == '0) begin
              root_left_q  <= ent_upd.left;
              root_right_q <= ent_upd.right;
            end
            if (ld_alloc) begin
              next_free_q <= next_free_q + CNT_W'(1);
            end
            if (ld_last) begin
              leaf_idx_q <= new_idx;
              state_q    <= S_LEAF;
            end else begin
              // Descend either into a fresh node or into one whose entry
              // arrives from the memory in the next cycle.
              ld_node_q <= ld_alloc ? new_idx : ld_child;
              fresh_q   <= ld_alloc;
              pos_q     <= pos_q - LEN_W'(1);
            end
          end
        end

        S_LEAF: begin
          if (out_free) begin
            sym_valid_q <= 1'b0;
            sym_out_q   <= '0;
            status_q    <= ST_OK;
            state_q     <= S_IDLE;
          end
        end

        S_DEC: begin
          if (dec_child != '0) begin
            cur_q   <= dec_child;
            state_q <= S_IDLE;
          end else if (out_free) begin
            // No child on this side: emit the leaf, or a bad-path status if the node is no leaf or the root
            // has no child for the same bit, and restart from the root's child for that bit.
            sym_valid_q <= ent.leaf;
            sym_out_q   <= ent.leaf ? ent.sym : '0;
            status_q    <= (!ent.leaf || root_child == '0) ? ST_BADPATH : ST_OK;
            cur_q       <= root_child;
            state_q     <= S_IDLE;
          end
        end

        S_END: begin
          if (!end_emit) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            sym_valid_q <= ent.leaf;
            sym_out_q   <= ent.leaf ? ent.sym : '0;
            status_q    <= ent.leaf ? ST_OK : ST_BADPATH;
            cur_q       <= '0;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/htbd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module htbd_checker
  import htbd_pkg::*;
(
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_stall_o,
  input wire [CMD_W-1:0]    command_i,
  input wire                out_valid_o,
  input wire                out_stall_i,
  input wire                symbol_valid_o,
  input wire [SYM_W-1:0]    symbol_out_o,
  input wire [STATUS_W-1:0] status_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(symbol_valid_o) && $stable(symbol_out_o) && $stable(status_o))
    else $error("result payload changed while stalled");

  // Without a decoded symbol the symbol field is zero.
  a_sym_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !symbol_valid_o |-> symbol_out_o == '0)
    else $error("symbol field set without a decoded symbol");

  // Load failures never carry a symbol.
  a_load_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL || status_o == ST_BADLEN) |-> !symbol_valid_o)
    else $error("symbol emitted with a load status");

  // A real command that is taken makes the block busy and stalls the item channel.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
      (command_i == CMD_LOAD || command_i == CMD_DECODE || command_i == CMD_END)
      |=> in_stall_o)
    else $error("next item taken while a command is in progress");

endmodule

bind huffman_tree_bit_decoder_unit htbd_checker u_htbd_checker (.*);

`default_nettype wire
